/* hdl/pfba_pkg.sv */
package pfba_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned BIT_W     = 5;
  localparam int unsigned ADDR_W    = 52;
  localparam int unsigned USED_W    = 16;
  localparam int unsigned TOTAL_W   = 32;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_OOM   = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ADD,
    S_SCAN,
    S_CLR,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] phys_address;
    logic [ADDR_W-1:0] region_length;
    logic              region_usable;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ADDR_W-1:0]  page_address;
    logic [USED_W-1:0]  used_count;
    logic [TOTAL_W-1:0] total_count;
  } out_item_t;

  // map memory request; addresses travel beside it
  typedef struct packed {
    logic  rd_en;
    logic  wr_en;
    word_t wr_mask;
    word_t wr_data;
  } map_req_t;

  // index of the lowest set bit, 0 when none is set
  function automatic logic [BIT_W-1:0] lowest_one(input word_t w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

/* hdl/pfba_map_mem.sv */
module pfba_map_mem
  import pfba_pkg::*;
#(
  parameter int unsigned NUM_WORDS = 1024,
  localparam int unsigned WI_W     = $clog2(NUM_WORDS)
) (
  input  logic            clk_i,
  input  map_req_t        req_i,
  input  logic [WI_W-1:0] rd_addr_i,
  input  logic [WI_W-1:0] wr_addr_i,
  output word_t           rd_data_o
);

  word_t mem_q [NUM_WORDS];
  word_t rd_data_q;

  // one read and one bit-masked write per cycle, read data registered
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) rd_data_q <= mem_q[rd_addr_i];
    for (int i = 0; i < WORD_BITS; i++) begin
      if (req_i.wr_en && req_i.wr_mask[i]) mem_q[wr_addr_i][i] <= req_i.wr_data[i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hdl/pfba_ctrl.sv */
module pfba_ctrl
  import pfba_pkg::*;
#(
  parameter int unsigned MAP_BYTES  = 4096,
  parameter int unsigned PAGE_BYTES = 4096,
  localparam int unsigned MAP_PAGES = MAP_BYTES * 8,
  localparam int unsigned NUM_WORDS = (MAP_PAGES + WORD_BITS - 1) / WORD_BITS,
  localparam int unsigned WI_W      = $clog2(NUM_WORDS)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_data_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output out_item_t       res_o,
  output map_req_t        mem_req_o,
  output logic [WI_W-1:0] mem_rd_addr_o,
  output logic [WI_W-1:0] mem_wr_addr_o,
  input  word_t           mem_rd_data_i
);

  localparam int unsigned PN_W       = $clog2(MAP_PAGES + 1);
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned LAST_BITS  = MAP_PAGES - (NUM_WORDS - 1) * WORD_BITS;
  localparam word_t       LAST_MASK  = word_t'((64'd1 << LAST_BITS) - 64'd1);
  localparam word_t       ONES       = '1;

  state_e               state_q, state_d;
  logic                 init_q, init_d;
  in_item_t             in_q, in_d;
  logic [PN_W-1:0]      hint_q, hint_d;
  logic [USED_W-1:0]    used_q, used_d;
  logic [TOTAL_W-1:0]   total_q, total_d;
  logic [PN_W-1:0]      beg_q, beg_d;
  logic [PN_W-1:0]      end_q, end_d;
  logic [WI_W-1:0]      wcur_q, wcur_d;
  logic [WI_W:0]        rdw_q, rdw_d;
  logic                 pend_q, pend_d;
  logic [WI_W-1:0]      chk_q, chk_d;
  status_e              stat_q, stat_d;
  logic [ADDR_W-1:0]    raddr_q, raddr_d;

  // decode of the held item
  logic [ADDR_W-1:0]  first_pg, cnt_pg;
  logic [ADDR_W:0]    sum_pg;
  logic               first_in;
  logic [PN_W-1:0]    end_clip;
  logic               add_empty;
  logic [WI_W-1:0]    hint_word;

  assign first_pg  = in_q.phys_address >> PAGE_SHIFT;
  assign cnt_pg    = in_q.region_length >> PAGE_SHIFT;
  assign sum_pg    = {1'b0, first_pg} + {1'b0, cnt_pg};
  assign first_in  = first_pg < ADDR_W'(MAP_PAGES);
  assign end_clip  = (sum_pg > (ADDR_W + 1)'(MAP_PAGES)) ? PN_W'(MAP_PAGES)
                                                         : sum_pg[PN_W-1:0];
  assign add_empty = !first_in || (first_pg[PN_W-1:0] >= end_clip);
  assign hint_word = hint_q[BIT_W +: WI_W];

  // region add sweep
  logic [PN_W-1:0]  last_pg;
  logic [WI_W-1:0]  beg_word, last_word;
  word_t            add_mask;
  logic [PN_W:0]    total_sum;

  assign last_pg   = end_q - PN_W'(1);
  assign beg_word  = beg_q[BIT_W +: WI_W];
  assign last_word = last_pg[BIT_W +: WI_W];
  assign add_mask  = ((wcur_q == beg_word)  ? (ONES << beg_q[BIT_W-1:0]) : ONES) &
                     ((wcur_q == last_word) ? (ONES >> (BIT_W'(WORD_BITS - 1) -
                                                        last_pg[BIT_W-1:0])) : ONES);
  assign total_sum = (PN_W + 1)'(end_q - beg_q);

  logic [TOTAL_W:0] total_add;
  assign total_add = {1'b0, total_q} + (TOTAL_W + 1)'(total_sum);

  // allocate scan: read one word a cycle, check the previous one
  logic             issue;
  word_t            free_v;
  logic             found;
  logic [BIT_W-1:0] found_bit;
  logic [PN_W-1:0]  found_pg;

  assign issue     = rdw_q < (WI_W + 1)'(NUM_WORDS);
  assign free_v    = ~mem_rd_data_i
                     & ((chk_q == WI_W'(NUM_WORDS - 1)) ? LAST_MASK : ONES)
                     & ((chk_q == hint_word) ? (ONES << hint_q[BIT_W-1:0]) : ONES);
  assign found     = pend_q && (free_v != '0);
  assign found_bit = lowest_one(free_v);
  assign found_pg  = PN_W'({chk_q, found_bit});

  logic clr_last;
  assign clr_last = wcur_q == WI_W'(NUM_WORDS - 1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (action_e'(in_q.action))
          ACT_ADD: begin
            if (in_q.region_usable && first_in && !add_empty) state_d = S_ADD;
            else state_d = S_RESP;
          end
          ACT_ALLOC: begin
            if (hint_q < PN_W'(MAP_PAGES)) state_d = S_SCAN;
            else state_d = S_RESP;
          end
          ACT_FREE:  state_d = S_RESP;
          ACT_CLEAR: state_d = S_CLR;
          default:   state_d = S_RESP;
        endcase
      end
      S_ADD: begin
        if (wcur_q == last_word) state_d = S_RESP;
      end
      S_SCAN: begin
        if (found || (pend_q && !issue)) state_d = S_RESP;
      end
      S_CLR: begin
        if (clr_last) state_d = init_q ? S_IDLE : S_RESP;
      end
      S_RESP: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    init_d        = init_q;
    in_d          = in_q;
    hint_d        = hint_q;
    used_d        = used_q;
    total_d       = total_q;
    beg_d         = beg_q;
    end_d         = end_q;
    wcur_d        = wcur_q;
    rdw_d         = rdw_q;
    pend_d        = 1'b0;
    chk_d         = chk_q;
    stat_d        = stat_q;
    raddr_d       = raddr_q;
    mem_req_o     = '0;
    mem_rd_addr_o = rdw_q[WI_W-1:0];
    mem_wr_addr_o = wcur_q;
    in_stall_o    = state_q != S_IDLE;
    res_valid_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) in_d = in_data_i;
      end
      S_DECODE: begin
        stat_d  = STAT_DONE;
        raddr_d = '0;
        case (action_e'(in_q.action))
          ACT_ADD: begin
            if (in_q.region_usable && cnt_pg != '0 && !first_in) stat_d = STAT_RANGE;
            beg_d  = first_pg[PN_W-1:0];
            end_d  = end_clip;
            wcur_d = first_pg[BIT_W +: WI_W];
          end
          ACT_ALLOC: begin
            rdw_d = {1'b0, hint_word};
            if (hint_q >= PN_W'(MAP_PAGES)) stat_d = STAT_OOM;
          end
          ACT_FREE: begin
            if (!first_in) begin
              stat_d = STAT_RANGE;
            end else begin
              mem_req_o.wr_en   = 1'b1;
              mem_req_o.wr_mask = word_t'(1) << first_pg[BIT_W-1:0];
              mem_req_o.wr_data = '0;
              mem_wr_addr_o     = first_pg[BIT_W +: WI_W];
              if (used_q != '0) used_d = used_q - USED_W'(1);
              if (first_pg[PN_W-1:0] < hint_q) hint_d = first_pg[PN_W-1:0];
            end
          end
          ACT_CLEAR: wcur_d = '0;
          default: ;
        endcase
      end
      S_ADD: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_mask = add_mask;
        mem_req_o.wr_data = '0;
        wcur_d            = wcur_q + WI_W'(1);
        if (wcur_q == last_word) total_d = total_add[TOTAL_W] ? '1 : total_add[TOTAL_W-1:0];
      end
      S_SCAN: begin
        mem_req_o.rd_en = issue;
        pend_d          = issue;
        chk_d           = rdw_q[WI_W-1:0];
        if (issue) rdw_d = rdw_q + (WI_W + 1)'(1);
        mem_wr_addr_o = chk_q;
        if (found) begin
          mem_req_o.wr_en   = 1'b1;
          mem_req_o.wr_mask = word_t'(1) << found_bit;
          mem_req_o.wr_data = '1;
          hint_d            = found_pg + PN_W'(1);
          if (used_q != '1) used_d = used_q + USED_W'(1);
          raddr_d           = ADDR_W'(found_pg) << PAGE_SHIFT;
        end else if (pend_q && !issue) begin
          stat_d = STAT_OOM;
        end
      end
      S_CLR: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_mask = '1;
        mem_req_o.wr_data = '1;
        wcur_d            = wcur_q + WI_W'(1);
        total_d           = '0;
        if (clr_last) init_d = 1'b0;
      end
      S_RESP: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign res_o = '{status:       stat_q,
                   page_address: raddr_q,
                   used_count:   used_q,
                   total_count:  total_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      init_q  <= 1'b1;
      hint_q  <= '0;
      used_q  <= '0;
      total_q <= '0;
      wcur_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      hint_q  <= hint_d;
      used_q  <= used_d;
      total_q <= total_d;
      wcur_q  <= wcur_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q    <= in_d;
    beg_q   <= beg_d;
    end_q   <= end_d;
    rdw_q   <= rdw_d;
    chk_q   <= chk_d;
    stat_q  <= stat_d;
    raddr_q <= raddr_d;
  end

endmodule

/* hdl/page_frame_bitmap_allocator_core.sv */
// Page frame allocator over a used-page bitmap (1 = used) held in a 32-bit
// wide on-chip memory, MAP_BYTES*8 pages of PAGE_BYTES each.
// Input channel in_valid_i / in_stall_o / in_data_i carries one action item:
// add region, allocate, free, clear map. Output channel out_valid_o /
// out_stall_i / out_data_o returns exactly one result item per input item.
// One item is processed at a time; the memory's single write port sets the
// pace. With W = MAP_BYTES*8/32 words, each accepted item is decoded, then:
//   free, ignored add/free  : straight to the result
//   allocate                : scan of words from the hint word on
//   region add              : write of each word the region touches
//   clear map               : write of all W words
// A new item is taken the cycle after a result moves into the output
// register, even while that result is still stalled downstream. A result
// waiting behind a stalled output holds the block until the register frees.
// After reset the map's W words (1024 at default sizes) are swept to all
// used, one word a cycle, with in_stall_o high; counts and hint reset to zero.
module page_frame_bitmap_allocator_core
  import pfba_pkg::*;
#(
  parameter int unsigned MAP_BYTES  = 4096,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned MAP_PAGES = MAP_BYTES * 8;
  localparam int unsigned NUM_WORDS = (MAP_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WI_W      = $clog2(NUM_WORDS);

  map_req_t        mem_req;
  logic [WI_W-1:0] mem_rd_addr, mem_wr_addr;
  word_t           mem_rd_data;
  logic            res_valid, res_ready;
  out_item_t       res;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q;

  pfba_ctrl #(
    .MAP_BYTES  (MAP_BYTES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_req_o     (mem_req),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_rd_data_i (mem_rd_data)
  );

  pfba_map_mem #(
    .NUM_WORDS (NUM_WORDS)
  ) u_map_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_addr_i (mem_rd_addr),
    .wr_addr_i (mem_wr_addr),
    .rd_data_o (mem_rd_data)
  );

  // output register: loads when empty or being drained this cycle
  assign res_ready   = !out_valid_q || !out_stall_i;
  assign out_valid_d = (res_valid && res_ready) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
